// ===== src/spcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spcsc_pkg
// Shared types and codes for the sparse pattern row-to-column converter.
// ----------------------------------------------------------------------------
package spcsc_pkg;

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 10;
    localparam int POS_W    = 14;
    localparam int DATA_W   = 14;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RD_PTR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RD_ROW  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PHASE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
        logic [POS_W-1:0]   position;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLR,
        S_CNT_RD,
        S_CNT_PTR,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_SCT_RD,
        S_SCT_SLOT,
        S_SCT_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic idx_clr;
        logic ptr_clr_wr;
        logic ent_rd;
        logic cnt_ptr_rd;
        logic cnt_wr;
        logic pfx_rd;
        logic pfx_wr;
        logic slot_rd;
        logic sct_wr;
        logic finish;
        logic res_set;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              idx_eq_n;
        logic              idx_eq_cnt;
        logic              out_free;
    } sts_t;

endpackage

// ===== src/spcsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// spcsc_ctrl
// Sequencer for item decode and the clear, count, prefix and scatter passes.
// ----------------------------------------------------------------------------
module spcsc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spcsc_pkg::sts_t   sts,
    output spcsc_pkg::cmd_t   cmd,
    output spcsc_pkg::state_t state
);

    spcsc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spcsc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            spcsc_pkg::S_IDLE: begin
                s_ready = sts.out_free && aresetn;
                if (s_valid && s_ready) begin
                    cmd.accept = 1'b1;
                    state_next = spcsc_pkg::S_DECODE;
                end
            end
            spcsc_pkg::S_DECODE: begin
                cmd.exec = 1'b1;
                if (sts.kind == spcsc_pkg::KIND_COMPUTE) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = spcsc_pkg::S_CLR;
                end else begin
                    state_next = spcsc_pkg::S_RESULT;
                end
            end
            spcsc_pkg::S_CLR: begin
                cmd.ptr_clr_wr = 1'b1;
                if (sts.idx_eq_n) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = spcsc_pkg::S_CNT_RD;
                end
            end
            spcsc_pkg::S_CNT_RD: begin
                if (sts.idx_eq_cnt) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = spcsc_pkg::S_PFX_RD;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = spcsc_pkg::S_CNT_PTR;
                end
            end
            spcsc_pkg::S_CNT_PTR: begin
                cmd.cnt_ptr_rd = 1'b1;
                state_next     = spcsc_pkg::S_CNT_WR;
            end
            spcsc_pkg::S_CNT_WR: begin
                cmd.cnt_wr = 1'b1;
                state_next = spcsc_pkg::S_CNT_RD;
            end
            spcsc_pkg::S_PFX_RD: begin
                if (sts.idx_eq_n) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = spcsc_pkg::S_SCT_RD;
                end else begin
                    cmd.pfx_rd = 1'b1;
                    state_next = spcsc_pkg::S_PFX_WR;
                end
            end
            spcsc_pkg::S_PFX_WR: begin
                cmd.pfx_wr = 1'b1;
                state_next = spcsc_pkg::S_PFX_RD;
            end
            spcsc_pkg::S_SCT_RD: begin
                if (sts.idx_eq_cnt) begin
                    cmd.finish = 1'b1;
                    state_next = spcsc_pkg::S_RESULT;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = spcsc_pkg::S_SCT_SLOT;
                end
            end
            spcsc_pkg::S_SCT_SLOT: begin
                cmd.slot_rd = 1'b1;
                state_next  = spcsc_pkg::S_SCT_WR;
            end
            spcsc_pkg::S_SCT_WR: begin
                cmd.sct_wr = 1'b1;
                state_next = spcsc_pkg::S_SCT_RD;
            end
            spcsc_pkg::S_RESULT: begin
                cmd.res_set = 1'b1;
                state_next  = spcsc_pkg::S_IDLE;
            end
            default: begin
                state_next = spcsc_pkg::S_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ===== src/spcsc_dp.sv =====
// ----------------------------------------------------------------------------
// spcsc_dp
// Entry store, pointer and slot memories, output rows and result register.
// ----------------------------------------------------------------------------
module spcsc_dp #(
    parameter int MAX_ROWS     = 1024,
    parameter int MAX_NONZEROS = 8192
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [spcsc_pkg::CFG_W-1:0]  cfg_data,
    input  spcsc_pkg::in_word_t          s_data,
    output spcsc_pkg::out_word_t         m_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  spcsc_pkg::cmd_t              cmd,
    output spcsc_pkg::sts_t              sts
);

    localparam int AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int CW = $clog2(MAX_NONZEROS + 1);
    localparam int PW = $clog2(MAX_ROWS + 1);
    localparam int SW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int IW = (CW > PW) ? CW : PW;
    localparam int IXW = spcsc_pkg::INDEX_W;

    logic [IXW-1:0] ent_row_mem [MAX_NONZEROS];
    logic [IXW-1:0] ent_col_mem [MAX_NONZEROS];
    logic [CW-1:0]  ptr_mem     [MAX_ROWS+1];
    logic [CW-1:0]  slot_mem    [MAX_ROWS];
    logic [IXW-1:0] out_mem     [MAX_NONZEROS];

    spcsc_pkg::in_word_t  item_reg;
    spcsc_pkg::out_word_t m_data_reg;
    logic                 m_valid_reg;
    logic [spcsc_pkg::CFG_W-1:0] num_rows_reg;
    logic [CW-1:0]  count_reg;
    logic           computed_reg;
    logic [PW-1:0]  done_cols_reg;
    logic [CW-1:0]  placed_reg;
    logic [IW-1:0]  idx_reg;
    logic [CW-1:0]  sum_reg;
    logic [spcsc_pkg::STATUS_W-1:0] stat_reg;
    logic [IXW-1:0] ent_row_q, ent_col_q, out_q;
    logic [CW-1:0]  ptr_q, slot_q;

    logic [PW-1:0]  n;
    logic [spcsc_pkg::STATUS_W-1:0] stat_now;
    logic           ent_ok;
    logic           ptr_we, ptr_re;
    logic [PW-1:0]  ptr_waddr, ptr_raddr;
    logic [CW-1:0]  ptr_wdata, sum_add;
    logic [spcsc_pkg::DATA_W-1:0] res_data;

    always_comb begin
        if (num_rows_reg == '0) begin
            n = PW'(1);
        end else if (32'(num_rows_reg) > 32'(MAX_ROWS)) begin
            n = PW'(MAX_ROWS);
        end else begin
            n = PW'(num_rows_reg);
        end
    end

    // status of the latched item, sampled at decode
    always_comb begin
        stat_now = spcsc_pkg::ST_OK;
        case (item_reg.kind)
            spcsc_pkg::KIND_LOAD: begin
                if (computed_reg) begin
                    stat_now = spcsc_pkg::ST_PHASE;
                end else if (32'(item_reg.row) >= 32'(n) || 32'(item_reg.col) >= 32'(n)) begin
                    stat_now = spcsc_pkg::ST_RANGE;
                end else if (32'(count_reg) >= 32'(MAX_NONZEROS)) begin
                    stat_now = spcsc_pkg::ST_FULL;
                end
            end
            spcsc_pkg::KIND_COMPUTE: stat_now = spcsc_pkg::ST_OK;
            spcsc_pkg::KIND_RD_PTR: begin
                if (!computed_reg) begin
                    stat_now = spcsc_pkg::ST_PHASE;
                end else if (32'(item_reg.position) > 32'(done_cols_reg)) begin
                    stat_now = spcsc_pkg::ST_RANGE;
                end
            end
            spcsc_pkg::KIND_RD_ROW: begin
                if (!computed_reg) begin
                    stat_now = spcsc_pkg::ST_PHASE;
                end else if (32'(item_reg.position) >= 32'(placed_reg)
                             || 32'(item_reg.position) >= 32'(MAX_NONZEROS)) begin
                    stat_now = spcsc_pkg::ST_RANGE;
                end
            end
            spcsc_pkg::KIND_CLEAR: stat_now = spcsc_pkg::ST_OK;
            default: stat_now = spcsc_pkg::ST_RANGE;
        endcase
    end

    assign ent_ok  = (32'(ent_row_q) < 32'(n)) && (32'(ent_col_q) < 32'(n));
    assign sum_add = sum_reg + ptr_q;

    // pointer memory port selection
    always_comb begin
        ptr_we    = 1'b0;
        ptr_waddr = PW'(idx_reg);
        ptr_wdata = '0;
        if (cmd.ptr_clr_wr) begin
            ptr_we = 1'b1;
        end else if (cmd.cnt_wr) begin
            ptr_we    = ent_ok;
            ptr_waddr = PW'(32'(ent_col_q) + 32'd1);
            ptr_wdata = ptr_q + CW'(1);
        end else if (cmd.pfx_wr) begin
            ptr_we    = 1'b1;
            ptr_waddr = PW'(32'(idx_reg) + 32'd1);
            ptr_wdata = sum_add;
        end
    end

    always_comb begin
        ptr_re    = 1'b0;
        ptr_raddr = PW'(item_reg.position);
        if (cmd.cnt_ptr_rd) begin
            ptr_re    = 1'b1;
            ptr_raddr = PW'(32'(ent_col_q) + 32'd1);
        end else if (cmd.pfx_rd) begin
            ptr_re    = 1'b1;
            ptr_raddr = PW'(32'(idx_reg) + 32'd1);
        end else if (cmd.exec && item_reg.kind == spcsc_pkg::KIND_RD_PTR) begin
            ptr_re = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && item_reg.kind == spcsc_pkg::KIND_LOAD
            && stat_now == spcsc_pkg::ST_OK) begin
            ent_row_mem[AW'(count_reg)] <= item_reg.row;
            ent_col_mem[AW'(count_reg)] <= item_reg.col;
        end
        if (cmd.ent_rd) begin
            ent_row_q <= ent_row_mem[AW'(idx_reg)];
            ent_col_q <= ent_col_mem[AW'(idx_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (ptr_we) begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        if (ptr_re) begin
            ptr_q <= ptr_mem[ptr_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pfx_wr) begin
            slot_mem[SW'(idx_reg)] <= sum_reg;
        end else if (cmd.sct_wr && ent_ok) begin
            slot_mem[SW'(ent_col_q)] <= slot_q + CW'(1);
        end
        if (cmd.slot_rd) begin
            slot_q <= slot_mem[SW'(ent_col_q)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sct_wr && ent_ok) begin
            out_mem[AW'(slot_q)] <= ent_row_q;
        end
        if (cmd.exec && item_reg.kind == spcsc_pkg::KIND_RD_ROW) begin
            out_q <= out_mem[AW'(item_reg.position)];
        end
    end

    // walk index and running sum
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            stat_reg <= stat_now;
            sum_reg  <= '0;
        end else if (cmd.pfx_wr) begin
            sum_reg <= sum_add;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.ptr_clr_wr || cmd.cnt_wr || cmd.pfx_wr || cmd.sct_wr) begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    always_comb begin
        res_data = '0;
        case (item_reg.kind)
            spcsc_pkg::KIND_LOAD:    res_data = spcsc_pkg::DATA_W'(count_reg);
            spcsc_pkg::KIND_COMPUTE: res_data = spcsc_pkg::DATA_W'(placed_reg);
            spcsc_pkg::KIND_RD_PTR: begin
                if (stat_reg == spcsc_pkg::ST_OK) begin
                    res_data = spcsc_pkg::DATA_W'(ptr_q);
                end
            end
            spcsc_pkg::KIND_RD_ROW: begin
                if (stat_reg == spcsc_pkg::ST_OK) begin
                    res_data = spcsc_pkg::DATA_W'(out_q);
                end
            end
            default: res_data = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            m_data_reg.data   <= res_data;
            m_data_reg.status <= stat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg  <= spcsc_pkg::CFG_W'(1);
            count_reg     <= '0;
            computed_reg  <= 1'b0;
            done_cols_reg <= '0;
            placed_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                num_rows_reg <= cfg_data;
            end
            if (cmd.exec && item_reg.kind == spcsc_pkg::KIND_LOAD
                && stat_now == spcsc_pkg::ST_OK) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.exec && item_reg.kind == spcsc_pkg::KIND_CLEAR) begin
                count_reg     <= '0;
                computed_reg  <= 1'b0;
                done_cols_reg <= '0;
                placed_reg    <= '0;
            end
            if (cmd.finish) begin
                done_cols_reg <= n;
                placed_reg    <= sum_reg;
                computed_reg  <= 1'b1;
            end
            if (cmd.res_set) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.kind       = item_reg.kind;
    assign sts.idx_eq_n   = (32'(idx_reg) == 32'(n));
    assign sts.idx_eq_cnt = (32'(idx_reg) == 32'(count_reg));
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

endmodule

// ===== src/sparse_pattern_csr_to_csc_top.sv =====
// ----------------------------------------------------------------------------
// sparse_pattern_csr_to_csc_top
// Sparse pattern transpose from row-compressed to column-compressed form.
//
//   channel  ports                      payload
//   input    s_valid s_ready s_data     kind, row, col, position
//   result   m_valid m_ready m_data     data, status
//   config   cfg_valid cfg_ready        cfg_data: num_rows
//
// load, read, clear and unknown words pass through accept, decode and result
// compute: clear, count, prefix and scatter passes over nnz stored entries;
// each nonzero takes a read, modify and write turn on the pointer and slot
// memories in two passes
// no clearing pass after reset; the stores hold garbage until written
// s_ready is low while a word is at work; a stalled result holds m_data
// ----------------------------------------------------------------------------
module sparse_pattern_csr_to_csc_top #(
    parameter int MAX_ROWS     = 1024,
    parameter int MAX_NONZEROS = 8192
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  spcsc_pkg::in_word_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output spcsc_pkg::out_word_t         m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spcsc_pkg::CFG_W-1:0]  cfg_data
);

    spcsc_pkg::cmd_t   cmd;
    spcsc_pkg::sts_t   sts;
    spcsc_pkg::state_t state;

    assign cfg_ready = aresetn;

    spcsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .state   (state)
    );

    spcsc_dp #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state != spcsc_pkg::S_IDLE |-> !s_ready)
        else $error("input ready while busy");

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state == spcsc_pkg::S_DECODE && !m_valid)
        else $error("accepted word not decoded with empty result slot");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state == spcsc_pkg::S_RESULT |=> m_valid && state == spcsc_pkg::S_IDLE)
        else $error("result not presented");

endmodule
